/* src/sdms_pkg.sv */
// shared types and constants of the disc mask stamper
package sdms_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COORD_IN_W = 7;
  localparam int unsigned RSQ_W = 7;
  localparam logic [15:0] HALF_Q15 = 16'd16384;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] CRIT_RESET = 16'd32768;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIV_RATE = 3'd0,
    REG_DEATH_RATE = 3'd1,
    REG_DIV_RSQ = 3'd2,
    REG_DEATH_RSQ = 3'd3,
    REG_DIV_PERIOD = 3'd4,
    REG_DEATH_PERIOD = 3'd5,
    REG_CRIT = 3'd6,
    REG_CROWD = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_MUL_DIV,
    ST_DIVIDE,
    ST_MUL_CROWD,
    ST_MUL_DEATH,
    ST_STAMP,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic we;
    logic wdata;
    logic re;
  } map_ctl_t;

endpackage

/* src/sdms_map.sv */
// one-bit mask memory with registered read
module sdms_map #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW = 14
) (
  input  logic          clk,
  input  sdms_pkg::map_ctl_t ctl,
  input  logic [AW-1:0] addr,
  output logic          rdata
);
  import sdms_pkg::*;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end
endmodule

/* src/sdms_divider.sv */
// iterative restoring divider for the crowding ratio
module sdms_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        overflow,
  output logic [15:0] quotient
);
  import sdms_pkg::*;

  logic [15:0] rem;
  logic [4:0] cnt;
  logic [16:0] trial;

  assign trial = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'd16;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      overflow <= (dividend >= divisor);
      quotient <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= 16'(trial - {1'b0, divisor});
        quotient <= {quotient[14:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        quotient <= {quotient[14:0], 1'b0};
      end
    end
  end
endmodule

/* src/stochastic_disc_mask_stamper.sv */
// top level: sequencer, shared multiplier and two mask memories
//
//   channel | valid     | stall      | payload
//   in      | in_valid  | in_stall   | opcode node_x node_y density rand_division rand_death
//   out     | out_valid | out_stall  | division_bit death_bit division_regen death_regen
//   cfg     | cfg_write | -          | cfg_index cfg_data
//
// unused opcodes, idle samples and plain begin steps go straight to the response step; a read
// passes wrap and read; a drawing sample passes wrap (repeated while its disc corner wraps), the
// rate multiplies and, with crowding, the 16-step divider, plus a (2*MAX_RADIUS+1)^2 stamp sweep when a center arises
// a begin step that regenerates a mask first clears all GRID_WIDTH*GRID_HEIGHT cells of that mask
// after reset a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells holds in_stall high
// one item at a time; a finished beat waits in the output register while out_stall is high
module stochastic_disc_mask_stamper #(
  parameter int unsigned GRID_WIDTH = 128,
  parameter int unsigned GRID_HEIGHT = 128,
  parameter int unsigned MAX_RADIUS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [6:0]  node_x,
  input  logic [6:0]  node_y,
  input  logic [15:0] density,
  input  logic [15:0] rand_division,
  input  logic [15:0] rand_death,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        division_bit,
  output logic        death_bit,
  output logic        division_regen,
  output logic        death_regen,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sdms_pkg::*;

  localparam int unsigned CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned XW = $clog2(GRID_WIDTH);
  localparam int unsigned YW = $clog2(GRID_HEIGHT);
  localparam int unsigned MW = (XW > YW) ? XW : YW;
  localparam int unsigned CW = ((MW > 7) ? MW : 7) + 3;
  localparam int unsigned SPAN = 2 * MAX_RADIUS + 1;
  localparam int unsigned RW = $clog2(SPAN);
  localparam int unsigned DQW = 2 * (RW + 1);
  localparam int unsigned SQW = DQW + 1;
  localparam int unsigned LIM = MAX_RADIUS * MAX_RADIUS;

  // configuration
  logic [15:0] div_rate, dth_rate, division_period, death_period, critical_density;
  logic [RSQ_W-1:0] division_radius_sq, death_radius_sq;
  logic crowding_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_rate <= '0;
      dth_rate <= '0;
      division_radius_sq <= '0;
      death_radius_sq <= '0;
      division_period <= '0;
      death_period <= '0;
      critical_density <= CRIT_RESET;
      crowding_enable <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_DIV_RATE: div_rate <= cfg_data;
        REG_DEATH_RATE: dth_rate <= cfg_data;
        REG_DIV_RSQ: division_radius_sq <= cfg_data[RSQ_W-1:0];
        REG_DEATH_RSQ: death_radius_sq <= cfg_data[RSQ_W-1:0];
        REG_DIV_PERIOD: division_period <= cfg_data;
        REG_DEATH_PERIOD: death_period <= cfg_data;
        REG_CRIT: critical_density <= cfg_data;
        REG_CROWD: crowding_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic [1:0] op;
  logic [15:0] dens, rdiv, rdeath;
  logic [15:0] div_cd, death_cd;
  logic div_active, death_active;
  logic clr_div, clr_death, reset_pass;
  logic [AW:0] clr_cnt;
  logic signed [CW-1:0] xv, yv;
  logic [XW-1:0] x_cur;
  logic [YW-1:0] y_cur, y_start;
  logic [RW-1:0] dxc, dyc;
  logic [16:0] thr_div;
  logic div_ok;
  logic div_hit, death_hit;
  logic accept;

  // wrap status
  logic x_neg, y_neg, x_hi, y_hi, wrap_done;
  assign x_neg = xv < 0;
  assign y_neg = yv < 0;
  assign x_hi = xv >= CW'(GRID_WIDTH);
  assign y_hi = yv >= CW'(GRID_HEIGHT);
  assign wrap_done = !x_neg && !y_neg && !x_hi && !y_hi;

  // shared multiplier
  logic [16:0] mul_a, mul_b;
  logic [33:0] prod;
  logic [16:0] sat_thr;
  logic [15:0] quotient;
  logic div_busy, div_ovf, div_start;

  always_comb begin
    mul_a = {1'b0, dens};
    mul_b = {1'b0, div_rate};
    case (state)
      ST_MUL_DEATH: mul_b = {1'b0, dth_rate};
      ST_MUL_CROWD: begin
        mul_a = thr_div;
        mul_b = 17'(ONE_Q16 - {1'b0, quotient});
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;
  assign sat_thr = (prod[33:15] > {2'b0, ONE_Q16}) ? ONE_Q16 : prod[31:15];

  // disc geometry
  logic signed [RW:0] ddx, ddy;
  logic [SQW-1:0] dsq;
  logic [SQW-1:0] rr_div, rr_death;
  logic in_div, in_death, stamp_last;
  assign ddx = $signed({1'b0, dxc}) - (RW + 1)'(MAX_RADIUS);
  assign ddy = $signed({1'b0, dyc}) - (RW + 1)'(MAX_RADIUS);
  assign dsq = SQW'(DQW'(ddx * ddx)) + SQW'(DQW'(ddy * ddy));
  assign rr_div = (SQW'(division_radius_sq) > SQW'(LIM)) ? SQW'(LIM) : SQW'(division_radius_sq);
  assign rr_death = (SQW'(death_radius_sq) > SQW'(LIM)) ? SQW'(LIM) : SQW'(death_radius_sq);
  assign in_div = div_hit && (dsq <= rr_div);
  assign in_death = death_hit && (dsq <= rr_death);
  assign stamp_last = (dxc == RW'(SPAN - 1)) && (dyc == RW'(SPAN - 1));

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == (AW + 1)'(CELLS - 1)) begin
          state_next = reset_pass ? ST_IDLE : ST_RESP;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode_t'(opcode))
            OP_BEGIN: begin
              if (div_cd == '0 || death_cd == '0) begin
                state_next = ST_CLEAR;
              end else begin
                state_next = ST_RESP;
              end
            end
            OP_SAMPLE: begin
              if (density >= HALF_Q15 && (div_active || death_active)) begin
                state_next = ST_WRAP;
              end else begin
                state_next = ST_RESP;
              end
            end
            OP_READ: state_next = ST_WRAP;
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_WRAP: begin
        if (wrap_done) begin
          state_next = (opcode_t'(op) == OP_READ) ? ST_READ : ST_MUL_DIV;
        end
      end
      ST_MUL_DIV: state_next = crowding_enable ? ST_DIVIDE : ST_MUL_DEATH;
      ST_DIVIDE: begin
        if (!div_busy) begin
          state_next = ST_MUL_CROWD;
        end
      end
      ST_MUL_CROWD: state_next = ST_MUL_DEATH;
      ST_MUL_DEATH: begin
        if ((div_active && div_ok && {1'b0, rdiv} < thr_div)
            || (death_active && {1'b0, rdeath} < sat_thr)) begin
          state_next = ST_STAMP;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_STAMP: begin
        if (stamp_last) begin
          state_next = ST_RESP;
        end
      end
      ST_READ: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  map_ctl_t div_ctl, death_ctl;
  logic [AW-1:0] addr;

  always_comb begin
    div_ctl = '0;
    death_ctl = '0;
    addr = AW'(AW'(y_cur) * AW'(GRID_WIDTH) + AW'(x_cur));
    in_stall = (state != ST_IDLE);
    div_start = 1'b0;
    case (state)
      ST_CLEAR: begin
        addr = clr_cnt[AW-1:0];
        div_ctl.we = clr_div;
        death_ctl.we = clr_death;
      end
      ST_STAMP: begin
        div_ctl.we = in_div;
        div_ctl.wdata = 1'b1;
        death_ctl.we = in_death;
        death_ctl.wdata = 1'b1;
      end
      ST_READ: begin
        div_ctl.re = 1'b1;
        death_ctl.re = 1'b1;
      end
      ST_MUL_DIV: div_start = crowding_enable;
      default: ;
    endcase
  end

  logic div_rd, death_rd;

  sdms_map #(.DEPTH(CELLS), .AW(AW)) u_div_map (
    .clk(clk), .ctl(div_ctl), .addr(addr), .rdata(div_rd)
  );

  sdms_map #(.DEPTH(CELLS), .AW(AW)) u_death_map (
    .clk(clk), .ctl(death_ctl), .addr(addr), .rdata(death_rd)
  );

  sdms_divider u_divider (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dens),
    .divisor(critical_density), .busy(div_busy), .overflow(div_ovf),
    .quotient(quotient)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      clr_div <= 1'b1;
      clr_death <= 1'b1;
      reset_pass <= 1'b1;
      div_cd <= '0;
      death_cd <= '0;
      div_active <= 1'b0;
      death_active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (AW + 1)'(CELLS - 1)) begin
          reset_pass <= 1'b0;
        end
      end
      if (accept && opcode_t'(opcode) == OP_BEGIN) begin
        clr_cnt <= '0;
        clr_div <= (div_cd == '0);
        clr_death <= (death_cd == '0);
        div_active <= (div_cd == '0);
        death_active <= (death_cd == '0);
        div_cd <= (div_cd == '0) ? division_period : div_cd - 16'd1;
        death_cd <= (death_cd == '0) ? death_period : death_cd - 16'd1;
      end
      if (state == ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= opcode;
      dens <= density;
      rdiv <= rand_division;
      rdeath <= rand_death;
      div_ok <= 1'b1;
      if (opcode_t'(opcode) == OP_READ) begin
        xv <= CW'(node_x);
        yv <= CW'(node_y);
      end else begin
        xv <= CW'(node_x) - CW'(MAX_RADIUS);
        yv <= CW'(node_y) - CW'(MAX_RADIUS);
      end
    end
    case (state)
      ST_WRAP: begin
        if (x_neg) begin
          xv <= xv + CW'(GRID_WIDTH);
        end else if (x_hi) begin
          xv <= xv - CW'(GRID_WIDTH);
        end
        if (y_neg) begin
          yv <= yv + CW'(GRID_HEIGHT);
        end else if (y_hi) begin
          yv <= yv - CW'(GRID_HEIGHT);
        end
        x_cur <= xv[XW-1:0];
        y_cur <= yv[YW-1:0];
        y_start <= yv[YW-1:0];
        dxc <= '0;
        dyc <= '0;
      end
      ST_MUL_DIV: thr_div <= sat_thr;
      ST_MUL_CROWD: begin
        if (div_ovf) begin
          div_ok <= 1'b0;
        end else begin
          thr_div <= prod[32:16];
        end
      end
      ST_MUL_DEATH: begin
        div_hit <= div_active && div_ok && ({1'b0, rdiv} < thr_div);
        death_hit <= death_active && ({1'b0, rdeath} < sat_thr);
      end
      ST_STAMP: begin
        if (dyc == RW'(SPAN - 1)) begin
          dyc <= '0;
          dxc <= dxc + 1'b1;
          y_cur <= y_start;
          x_cur <= (x_cur == XW'(GRID_WIDTH - 1)) ? '0 : x_cur + 1'b1;
        end else begin
          dyc <= dyc + 1'b1;
          y_cur <= (y_cur == YW'(GRID_HEIGHT - 1)) ? '0 : y_cur + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          division_regen <= div_active;
          death_regen <= death_active;
          division_bit <= (opcode_t'(op) == OP_READ) ? div_rd : 1'b0;
          death_bit <= (opcode_t'(op) == OP_READ) ? death_rd : 1'b0;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("result beat without a response step");

  assert property (@(posedge clk) disable iff (rst)
    (div_ctl.we || death_ctl.we) |-> (state == ST_CLEAR || state == ST_STAMP))
    else $error("mask write outside clear or stamp");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> crowding_enable)
    else $error("divide step without crowding");
endmodule

/* test/stochastic_disc_mask_stamper_test.sv */
// testbench for the disc mask stamper: random and directed beats against a scoreboard
`timescale 1ns / 100ps

module stochastic_disc_mask_stamper_test;
  import sdms_pkg::*;

  localparam int GW = 128;
  localparam int GH = 128;
  localparam int MAXR = 8;

  typedef struct {
    bit div_bit;
    bit death_bit;
    bit div_regen;
    bit death_regen;
  } mask_beat_t;

  class mask_scoreboard;
    bit div_map [GW*GH];
    bit death_map [GW*GH];
    bit [15:0] div_count, dth_count;
    bit div_active, death_active;
    bit [15:0] div_rate, dth_rate, div_period, death_period, crit;
    bit [6:0] div_rsq, death_rsq;
    bit crowd;
    mask_beat_t pending[$];
    int errors;

    function void write_reg(reg_idx_t idx, bit [15:0] data);
      case (idx)
        REG_DIV_RATE: div_rate = data;
        REG_DEATH_RATE: dth_rate = data;
        REG_DIV_RSQ: div_rsq = data[6:0];
        REG_DEATH_RSQ: death_rsq = data[6:0];
        REG_DIV_PERIOD: div_period = data;
        REG_DEATH_PERIOD: death_period = data;
        REG_CRIT: crit = data;
        REG_CROWD: crowd = data[0];
        default: ;
      endcase
    endfunction

    function void init();
      foreach (div_map[i]) begin
        div_map[i] = 0;
        death_map[i] = 0;
      end
      div_count = 0;
      dth_count = 0;
      div_active = 0;
      death_active = 0;
      div_rate = 0;
      dth_rate = 0;
      div_rsq = 0;
      death_rsq = 0;
      div_period = 0;
      death_period = 0;
      crit = CRIT_RESET;
      crowd = 0;
      errors = 0;
    endfunction

    function void stamp(bit is_div, int cx, int cy, int rsq);
      int rr, px, py;
      rr = rsq > MAXR*MAXR ? MAXR*MAXR : rsq;
      for (int dx = -MAXR; dx <= MAXR; dx++)
        for (int dy = -MAXR; dy <= MAXR; dy++)
          if (dx*dx + dy*dy <= rr) begin
            px = (cx + dx + GW) % GW;
            py = (cy + dy + GH) % GH;
            if (is_div) div_map[py*GW+px] = 1;
            else death_map[py*GW+px] = 1;
          end
    endfunction

    function longint unsigned threshold(bit [15:0] rate, bit [15:0] dens);
      longint unsigned t;
      t = (longint'(rate) * longint'(dens)) >> 15;
      return t > 65536 ? 65536 : t;
    endfunction

    function void note(opcode_t op, bit [6:0] x, bit [6:0] y, bit [15:0] dens,
                       bit [15:0] rdiv, bit [15:0] rdeath);
      mask_beat_t b;
      longint unsigned thr, q;
      bit ok;
      b.div_bit = 0;
      b.death_bit = 0;
      case (op)
        OP_BEGIN: begin
          if (div_count == 0) begin
            foreach (div_map[i]) div_map[i] = 0;
            div_count = div_period;
            div_active = 1;
          end else begin
            div_count--;
            div_active = 0;
          end
          if (dth_count == 0) begin
            foreach (death_map[i]) death_map[i] = 0;
            dth_count = death_period;
            death_active = 1;
          end else begin
            dth_count--;
            death_active = 0;
          end
        end
        OP_SAMPLE: begin
          if (dens >= HALF_Q15) begin
            if (div_active) begin
              thr = threshold(div_rate, dens);
              ok = 1;
              if (crowd) begin
                if (crit == 0) ok = 0;
                else begin
                  q = (longint'(dens) << 16) / crit;
                  if (q >= 65536) ok = 0;
                  else thr = (thr * (65536 - q)) >> 16;
                end
              end
              if (ok && rdiv < thr) stamp(1, x, y, div_rsq);
            end
            if (death_active) begin
              thr = threshold(dth_rate, dens);
              if (rdeath < thr) stamp(0, x, y, death_rsq);
            end
          end
        end
        OP_READ: begin
          b.div_bit = div_map[y*GW+x];
          b.death_bit = death_map[y*GW+x];
        end
        default: ;
      endcase
      b.div_regen = div_active;
      b.death_regen = death_active;
      pending.push_back(b);
    endfunction

    function void check(bit db, bit deb, bit dr, bit der);
      mask_beat_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      if (e.div_bit !== db || e.death_bit !== deb || e.div_regen !== dr ||
          e.death_regen !== der) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at %0t: expected div %b death %b regen %b%b, got %b %b %b%b",
                   $realtime, e.div_bit, e.death_bit, e.div_regen, e.death_regen,
                   db, deb, dr, der);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] opcode = 0;
  logic [6:0] node_x = 0, node_y = 0;
  logic [15:0] density = 0, rand_division = 0, rand_death = 0;
  logic out_valid;
  logic out_stall = 0;
  logic division_bit, death_bit, division_regen, death_regen;
  logic cfg_write = 0;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  mask_scoreboard sb;
  bit quiet = 0;
  int stall_left = 0;
  int pause_left = 0;
  bit [13:0] recent_centers[$];

  stochastic_disc_mask_stamper i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    if (quiet) out_stall <= 0;
    else if (stall_left > 0) stall_left--;
    else if (pause_left > 0) begin
      pause_left--;
      if (pause_left == 0) out_stall <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1;
      pause_left = $urandom_range(1, 17);
    end else begin
      out_stall <= 0;
      stall_left = $urandom_range(0, 40);
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check(division_bit, death_bit, division_regen, death_regen);

  task automatic write_reg(reg_idx_t idx, bit [15:0] data);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 0;
    sb.write_reg(idx, data);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_all(bit [15:0] drate, bit [15:0] trate, bit [6:0] drsq, bit [6:0] trsq,
                         bit [15:0] dper, bit [15:0] tper, bit [15:0] crit, bit crowd);
    settle();
    write_reg(REG_DIV_RATE, drate);
    write_reg(REG_DEATH_RATE, trate);
    write_reg(REG_DIV_RSQ, drsq);
    write_reg(REG_DEATH_RSQ, trsq);
    write_reg(REG_DIV_PERIOD, dper);
    write_reg(REG_DEATH_PERIOD, tper);
    write_reg(REG_CRIT, crit);
    write_reg(REG_CROWD, crowd);
  endtask

  task automatic send(opcode_t op, bit [6:0] x, bit [6:0] y, bit [15:0] dens,
                      bit [15:0] rdiv, bit [15:0] rdeath);
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    opcode <= op;
    node_x <= x;
    node_y <= y;
    density <= dens;
    rand_division <= rdiv;
    rand_death <= rdeath;
    do @(posedge clk); while (in_stall);
    sb.note(op, x, y, dens, rdiv, rdeath);
    if (op == OP_SAMPLE) begin
      recent_centers.push_back({y, x});
      if (recent_centers.size() > 8) void'(recent_centers.pop_front());
    end
  endtask

  task automatic random_item();
    int pick;
    bit [13:0] c;
    bit [15:0] dens;
    pick = $urandom_range(0, 99);
    dens = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(16384, 65535));
    if (pick < 2)
      send(OP_BEGIN, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom));
    else if (pick < 5)
      send(OP_NONE, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom));
    else if (pick < 50)
      send(OP_SAMPLE, 7'($urandom), 7'($urandom), dens, 16'($urandom), 16'($urandom));
    else if (pick < 75 && recent_centers.size() > 0) begin
      c = recent_centers[$urandom_range(0, recent_centers.size() - 1)];
      send(OP_READ, c[6:0] + 7'($urandom_range(0, 18)) - 7'd9,
           c[13:7] + 7'($urandom_range(0, 18)) - 7'd9, 16'($urandom), 16'($urandom),
           16'($urandom));
    end else
      send(OP_READ, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom));
  endtask

  initial begin
    #(50_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    sb = new();
    sb.init();
    repeat (8) @(negedge clk);
    rst <= 0;

    // directed: full rates, oversized radius, corners and half density edges
    set_all(16'hFFFF, 16'hFFFF, 7'd127, 7'd64, 16'd0, 16'd0, 16'hFFFF, 1'b0);
    send(OP_READ, 0, 0, 0, 0, 0);
    send(OP_BEGIN, 0, 0, 0, 0, 0);
    send(OP_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(OP_READ, 7'd120, 7'd120, 0, 0, 0);
    send(OP_READ, 7'd8, 0, 0, 0, 0);
    send(OP_READ, 7'd9, 0, 0, 0, 0);
    send(OP_SAMPLE, 7'd127, 7'd127, 16'd16383, 0, 0);
    send(OP_READ, 7'd127, 7'd127, 0, 0, 0);
    send(OP_SAMPLE, 7'd64, 7'd64, 16'd16384, 0, 16'hFFFF);
    send(OP_SAMPLE, 7'd64, 7'd64, 16'd16384, 16'hFFFF, 0);
    send(OP_READ, 7'd64, 7'd64, 0, 0, 0);
    send(OP_NONE, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // crowding with zero critical density, then half and unity ratios
    set_all(16'hFFFF, 16'd0, 7'd9, 7'd0, 16'd1, 16'd0, 16'd0, 1'b1);
    send(OP_BEGIN, 0, 0, 0, 0, 0);
    send(OP_SAMPLE, 7'd30, 7'd30, 16'hFFFF, 0, 0);
    send(OP_READ, 7'd30, 7'd30, 0, 0, 0);
    settle();
    write_reg(REG_CRIT, 16'hFFFF);
    send(OP_SAMPLE, 7'd40, 7'd40, 16'd32768, 0, 0);
    send(OP_SAMPLE, 7'd50, 7'd50, 16'hFFFF, 0, 0);
    send(OP_READ, 7'd40, 7'd41, 0, 0, 0);
    send(OP_READ, 7'd50, 7'd50, 0, 0, 0);
    send(OP_BEGIN, 0, 0, 0, 0, 0);
    send(OP_READ, 7'd40, 7'd40, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      set_all(ph == 0 ? 16'hFFFF : 16'($urandom),
              ph == 1 ? 16'd0 : 16'($urandom),
              ph == 2 ? 7'd0 : 7'($urandom_range(0, 80)),
              ph == 3 ? 7'd127 : 7'($urandom_range(0, 70)),
              ph == 4 ? 16'hFFFF : 16'($urandom_range(0, 3)),
              16'($urandom_range(0, 3)),
              ph == 5 ? 16'd1 : 16'($urandom_range(16384, 65535)),
              1'($urandom_range(0, 1)));
      send(OP_BEGIN, 0, 0, 0, 0, 0);
      if (ph == 5) quiet = 1;
      repeat (213) random_item();
    end

    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

/* filelist.f */
src/sdms_pkg.sv
src/sdms_map.sv
src/sdms_divider.sv
src/stochastic_disc_mask_stamper.sv
test/stochastic_disc_mask_stamper_test.sv
